/* design/fbde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_pkg
// Shared types, request codes and the 5x7 font for the page frame buffer
// drawing engine.
// ----------------------------------------------------------------------------
package fbde_pkg;

  // sized for the largest screen (256 columns by 128 rows)
  localparam int COL_W  = 9;
  localparam int ROW_W  = 8;
  localparam int PAGE_W = ROW_W - 3;
  localparam int ADDR_W = 12;

  localparam logic [2:0] REQ_CLEAR   = 3'd0;
  localparam logic [2:0] REQ_PIXEL   = 3'd1;
  localparam logic [2:0] REQ_FILL    = 3'd2;
  localparam logic [2:0] REQ_OUTLINE = 3'd3;
  localparam logic [2:0] REQ_GLYPH   = 3'd4;
  localparam logic [2:0] REQ_READ    = 3'd5;

  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd126;
  localparam logic [7:0] FALLBACK_CODE = 8'd63;
  localparam int         GLYPH_ROWS    = 7;
  localparam logic [2:0] GLYPH_LAST_COL = 3'd4;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_SETUP,
    ST_CLIP,
    ST_WALK,
    ST_RD_ISSUE,
    ST_RD_DATA
  } fbde_state_t;

  // one clipped span of columns and rows, walked byte by byte
  typedef struct packed {
    logic [COL_W-1:0]  c0;
    logic [COL_W-1:0]  c_last;
    logic [PAGE_W-1:0] p0;
    logic [PAGE_W-1:0] p_last;
    logic [ROW_W-1:0]  r0;
    logic [ROW_W-1:0]  r1;
    logic [7:0]        pat;
    logic [2:0]        yoff;
  } fbde_span_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } fbde_access_t;

  // columns left to right, bit n is row n
  localparam logic [39:0] FONT [95] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_40_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08
  };

  function automatic logic [7:0] glyph_column(input logic [6:0] idx, input logic [2:0] col);
    logic [39:0] e;
    logic [7:0]  c;
    e = FONT[idx];
    case (col)
      3'd0:    c = e[39:32];
      3'd1:    c = e[31:24];
      3'd2:    c = e[23:16];
      3'd3:    c = e[15:8];
      default: c = e[7:0];
    endcase
    return {1'b0, c[GLYPH_ROWS-1:0]};
  endfunction

endpackage

/* design/page_framebuffer_draw_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Drawing engine over a monochrome page-organized frame store.
// ----------------------------------------------------------------------------
// One request at a time. Every drawn byte goes through a read-modify-write of
// the single-port-write store at one byte per cycle, after a SETUP and a CLIP
// state per span: a fill w columns by p pages walks w*p bytes, an outline is
// four spans, a glyph five one-column spans. A clear writes every byte once,
// SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes (1024 at the default size); the same
// clearing pass runs after reset, while no word is accepted. A read request
// passes RD_ISSUE and RD_DATA and its word waits in an output register, so the
// block takes new requests while that word is stalled; a further read waits in RD_ISSUE.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] rect_width,
  input  logic signed [15:0] rect_height,
  input  logic               pixel_on,
  input  logic [7:0]         char_code,
  input  logic [9:0]         read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_byte
);
  import fbde_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic signed [17:0] W_S = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] H_S = 18'(SCREEN_HEIGHT);

  fbde_state_t state, state_next;

  logic [2:0]         op_r;
  logic signed [15:0] x_r, y_r, w_r, h_r;
  logic               on_r;
  logic [6:0]         gidx_r;
  logic [9:0]         ridx_r;
  logic               rd_ok;
  logic [2:0]         seg, seg_last;

  logic signed [17:0] bx0, bx1, by0, by1;
  logic signed [17:0] bx0_next, bx1_next, by0_next, by1_next;
  logic [7:0]         pat_r, pat_next;

  logic [AW-1:0]      wipe_cnt;
  logic               wr_pend;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_mask;
  logic [7:0]         rdata;

  logic               accept, walk_start, walk_last, rd_issue, nonempty;
  fbde_span_t         span;
  fbde_access_t       acc;

  logic signed [17:0] c0s, c1s, r0s, r1s, c1m, r1m;

  assign accept = in_valid && !in_stall;

  // clip the raw span to the screen
  always_comb begin
    c0s = (bx0 < 18'sd0) ? 18'sd0 : bx0;
    c1s = (bx1 > W_S) ? W_S : bx1;
    r0s = (by0 < 18'sd0) ? 18'sd0 : by0;
    r1s = (by1 > H_S) ? H_S : by1;
    c1m = c1s - 18'sd1;
    r1m = r1s - 18'sd1;
    nonempty    = (c0s < c1s) && (r0s < r1s);
    span.c0     = c0s[COL_W-1:0];
    span.c_last = c1m[COL_W-1:0];
    span.r0     = r0s[ROW_W-1:0];
    span.r1     = r1s[ROW_W-1:0];
    span.p0     = r0s[ROW_W-1:3];
    span.p_last = r1m[ROW_W-1:3];
    span.pat    = pat_r;
    span.yoff   = (op_r == REQ_GLYPH) ? y_r[2:0] : 3'd0;
  end

  // raw bounds of the current span, end exclusive
  always_comb begin
    logic signed [17:0] xs, ys, ws, hs, ss;
    xs = 18'(x_r);
    ys = 18'(y_r);
    ws = 18'(w_r);
    hs = 18'(h_r);
    ss = 18'(seg);
    bx0_next = xs;
    bx1_next = xs + 18'sd1;
    by0_next = ys;
    by1_next = ys + 18'sd1;
    pat_next = 8'hFF;
    case (op_r)
      REQ_FILL: begin
        bx1_next = xs + ws;
        by1_next = ys + hs;
      end
      REQ_OUTLINE: begin
        case (seg)
          3'd0: begin
            bx1_next = xs + ws;
          end
          3'd1: begin
            bx1_next = xs + ws;
            by0_next = ys + hs - 18'sd1;
            by1_next = ys + hs;
          end
          3'd2: begin
            by0_next = ys + 18'sd1;
            by1_next = ys + hs - 18'sd1;
          end
          default: begin
            bx0_next = xs + ws - 18'sd1;
            bx1_next = xs + ws;
            by0_next = ys + 18'sd1;
            by1_next = ys + hs - 18'sd1;
          end
        endcase
      end
      REQ_GLYPH: begin
        bx0_next = xs + ss;
        bx1_next = xs + ss + 18'sd1;
        by1_next = ys + 18'(GLYPH_ROWS);
        pat_next = glyph_column(gidx_r, seg);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    walk_start = 1'b0;
    rd_issue   = 1'b0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_WIPE: begin
        if (wipe_cnt == AW'(STORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_CLEAR:   state_next = ST_WIPE;
            REQ_PIXEL:   state_next = ST_SETUP;
            REQ_GLYPH:   state_next = ST_SETUP;
            REQ_FILL,
            REQ_OUTLINE: begin
              if (rect_width > 16'sd0 && rect_height > 16'sd0) begin
                state_next = ST_SETUP;
              end
            end
            REQ_READ:    state_next = ST_RD_ISSUE;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        state_next = ST_CLIP;
      end
      ST_CLIP: begin
        if (nonempty) begin
          walk_start = 1'b1;
          state_next = ST_WALK;
        end else if (seg == seg_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SETUP;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_next = (seg == seg_last) ? ST_IDLE : ST_SETUP;
        end
      end
      ST_RD_ISSUE: begin
        if (!out_valid || !out_stall) begin
          rd_issue   = 1'b1;
          state_next = ST_RD_DATA;
        end
      end
      ST_RD_DATA: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= req_type;
      x_r    <= x_pos;
      y_r    <= y_pos;
      w_r    <= rect_width;
      h_r    <= rect_height;
      on_r   <= pixel_on;
      ridx_r <= read_index;
      rd_ok  <= 32'(read_index) < STORE_BYTES;
      seg    <= 3'd0;
      if (char_code < FIRST_CODE || char_code > LAST_CODE) begin
        gidx_r <= 7'(FALLBACK_CODE - FIRST_CODE);
      end else begin
        gidx_r <= 7'(char_code - FIRST_CODE);
      end
      case (req_type)
        REQ_OUTLINE: seg_last <= 3'd3;
        REQ_GLYPH:   seg_last <= GLYPH_LAST_COL;
        default:     seg_last <= 3'd0;
      endcase
    end else if ((state == ST_CLIP && !nonempty) || (state == ST_WALK && walk_last)) begin
      seg <= seg + 3'd1;
    end
    if (state == ST_SETUP) begin
      bx0   <= bx0_next;
      bx1   <= bx1_next;
      by0   <= by0_next;
      by1   <= by1_next;
      pat_r <= pat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_cnt <= '0;
    end else if (accept) begin
      wipe_cnt <= '0;
    end else if (state == ST_WIPE) begin
      wipe_cnt <= wipe_cnt + 1'b1;
    end
  end

  // write half of the read-modify-write, in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= acc.en;
    end
    wr_addr <= acc.addr[AW-1:0];
    wr_mask <= acc.mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RD_DATA) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == ST_RD_DATA) begin
      read_byte <= rd_ok ? rdata : 8'd0;
    end
  end

  fbde_walk #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_walk (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .span  (span),
    .acc   (acc),
    .last  (walk_last)
  );

  fbde_store #(
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    ((state == ST_WIPE) || wr_pend),
    .waddr ((state == ST_WIPE) ? wipe_cnt : wr_addr),
    .wdata ((state == ST_WIPE) ? 8'd0 : (on_r ? (rdata | wr_mask) : (rdata & ~wr_mask))),
    .re    (acc.en || rd_issue),
    .raddr (acc.en ? acc.addr[AW-1:0] : AW'(ridx_r)),
    .rdata (rdata)
  );

endmodule

/* design/fbde_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_store
// Frame store memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbde_store #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/fbde_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_walk
// Span walker: steps column by column, page by page over a clipped span and
// issues one store byte access with its pixel mask per cycle.
// ----------------------------------------------------------------------------
module fbde_walk #(
  parameter int SCREEN_WIDTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  fbde_pkg::fbde_span_t   span,
  output fbde_pkg::fbde_access_t acc,
  output logic                last
);
  import fbde_pkg::*;

  logic              running;
  fbde_span_t        span_r;
  logic [COL_W-1:0]  col;
  logic [PAGE_W-1:0] page;
  logic [7:0]        mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      span_r  <= span;
      col     <= span.c0;
      page    <= span.p0;
    end else if (running) begin
      if (page == span_r.p_last) begin
        page <= span_r.p0;
        if (col == span_r.c_last) begin
          running <= 1'b0;
        end else begin
          col <= col + 1'b1;
        end
      end else begin
        page <= page + 1'b1;
      end
    end
  end

  always_comb begin
    logic [ROW_W-1:0] r;
    logic [2:0]       d;
    for (int b = 0; b < 8; b++) begin
      r = ROW_W'({page, 3'(b)});
      d = r[2:0] - span_r.yoff;
      mask[b] = (r >= span_r.r0) && (r < span_r.r1) && span_r.pat[d];
    end
  end

  assign acc.en   = running;
  assign acc.addr = ADDR_W'(col) + ADDR_W'(32'(page) * SCREEN_WIDTH);
  assign acc.mask = mask;
  assign last     = running && (page == span_r.p_last) && (col == span_r.c_last);

endmodule

/* bench/tb_page_framebuffer_draw_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_framebuffer_draw_engine
// Drives drawing requests with random gaps, keeps a shadow frame store and
// checks every read-back byte against it, with random output stalls.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_draw_engine;
  import fbde_pkg::*;

  class frame_shadow;
    bit [7:0] bytes_q [1024];
    bit [7:0] read_q [$];
    int errors;
    int checked;

    function void put_px(int px, int py, bit on);
      int idx;
      if (px < 0 || px >= 128 || py < 0 || py >= 64) return;
      idx = px + (py / 8) * 128;
      bytes_q[idx][py % 8] = on;
    endfunction

    function void wipe();
      foreach (bytes_q[i]) bytes_q[i] = 8'h00;
    endfunction

    // apply one accepted request to the shadow store
    function void note_request(bit [2:0] kind, int x, int y, int w, int h, bit on,
                               bit [7:0] code, bit [9:0] ridx);
      int a0, a1, b0, b1;
      bit [39:0] g;
      bit [7:0] cbits;
      case (kind)
        REQ_CLEAR: wipe();
        REQ_PIXEL: put_px(x, y, on);
        REQ_FILL: begin
          if (w > 0 && h > 0) begin
            a0 = x < 0 ? 0 : x;
            b0 = y < 0 ? 0 : y;
            a1 = x + w > 128 ? 128 : x + w;
            b1 = y + h > 64 ? 64 : y + h;
            for (int i = a0; i < a1; i++)
              for (int j = b0; j < b1; j++) put_px(i, j, on);
          end
        end
        REQ_OUTLINE: begin
          if (w > 0 && h > 0) begin
            a0 = x < 0 ? 0 : x;
            a1 = x + w > 128 ? 128 : x + w;
            for (int i = a0; i < a1; i++) begin
              put_px(i, y, on);
              put_px(i, y + h - 1, on);
            end
            b0 = y + 1 < 0 ? 0 : y + 1;
            b1 = y + h - 1 > 64 ? 64 : y + h - 1;
            for (int j = b0; j < b1; j++) begin
              put_px(x, j, on);
              put_px(x + w - 1, j, on);
            end
          end
        end
        REQ_GLYPH: begin
          if (code < FIRST_CODE || code > LAST_CODE) code = FALLBACK_CODE;
          g = FONT[code - FIRST_CODE];
          for (int c = 0; c < 5; c++) begin
            cbits = g[39 - 8*c -: 8];
            for (int r = 0; r < 7; r++)
              if (cbits[r]) put_px(x + c, y + r, on);
          end
        end
        REQ_READ: read_q.push_back(ridx < 1024 ? bytes_q[ridx] : 8'h00);
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_read(bit [7:0] got);
      bit [7:0] want;
      checked++;
      if (read_q.size() == 0) begin
        report($sformatf("read byte %02h with none expected", got));
      end else begin
        want = read_q.pop_front();
        if (want !== got) begin
          report($sformatf("read_byte got %02h want %02h", got, want));
        end
      end
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [2:0] req_type = 0;
  logic signed [15:0] x_pos = 0, y_pos = 0, rect_width = 0, rect_height = 0;
  logic pixel_on = 0;
  logic [7:0] char_code = 0;
  logic [9:0] read_index = 0;
  logic out_valid, out_stall = 1;
  logic [7:0] read_byte;
  frame_shadow fs;
  int cycles = 0;
  bit hold_off = 0;
  int n_reads = 0;

  always #10 clk = ~clk;

  page_framebuffer_draw_engine uut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout");
      $display("** page_framebuffer_draw_engine: FAILED **");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) fs.check_read(read_byte);

  // receiver: random stalls per word, long hold-off once
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      out_stall <= gap != 0;
      if (gap != 0) begin
        repeat (gap) @(negedge clk);
        out_stall <= 0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send(bit [2:0] k, int x, int y, int w, int h, bit on,
                      bit [7:0] code, bit [9:0] ridx);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    req_type <= k; x_pos <= 16'(x); y_pos <= 16'(y);
    rect_width <= 16'(w); rect_height <= 16'(h);
    pixel_on <= on; char_code <= code; read_index <= ridx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fs.note_request(k, x, y, w, h, on, code, ridx);
    if (k == REQ_READ) n_reads++;
    @(negedge clk);
  endtask

  function automatic int rnd_coord(int lim);
    case ($urandom_range(0, 9))
      0: return $signed(16'($urandom));
      1: return -$urandom_range(0, 10);
      default: return $urandom_range(0, lim + 4);
    endcase
  endfunction

  task automatic rnd_item();
    bit [2:0] k;
    int r;
    int w, h;
    r = $urandom_range(0, 99);
    if (r < 35) k = REQ_READ;
    else if (r < 50) k = REQ_PIXEL;
    else if (r < 62) k = REQ_FILL;
    else if (r < 74) k = REQ_OUTLINE;
    else if (r < 94) k = REQ_GLYPH;
    else if (r < 96) k = REQ_CLEAR;
    else k = 3'($urandom_range(6, 7));
    w = ($urandom_range(0, 9) == 0) ? int'($signed(16'($urandom)))
                                    : int'($urandom_range(0, 40)) - 3;
    h = ($urandom_range(0, 9) == 0) ? int'($signed(16'($urandom)))
                                    : int'($urandom_range(0, 24)) - 3;
    send(k, rnd_coord(128), rnd_coord(64), w, h,
         $urandom_range(0, 3) != 0, 8'($urandom), 10'($urandom));
  endtask

  initial begin
    int waited;
    fs = new();
    fs.wipe();
    repeat (2) @(negedge clk);
    rst = 0;
    // directed: extremes and special cases
    send(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd0);
    send(REQ_PIXEL, 0, 0, 0, 0, 1, 0, 0);
    send(REQ_PIXEL, 127, 63, 0, 0, 1, 0, 0);
    send(REQ_PIXEL, -32768, 32767, 0, 0, 1, 0, 0);
    send(REQ_PIXEL, 32767, -32768, 0, 0, 1, 0, 0);
    send(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd1023);
    send(REQ_FILL, -32768, -32768, 32767, 32767, 1, 0, 0);
    send(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd515);
    send(REQ_FILL, 10, 10, 0, 5, 0, 0, 0);
    send(REQ_FILL, 10, 10, 5, -32768, 0, 0, 0);
    send(REQ_FILL, 32767, 32767, 32767, 32767, 0, 0, 0);
    send(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd515);
    send(REQ_OUTLINE, -2, -2, 200, 100, 1, 0, 0);
    send(REQ_OUTLINE, 5, 3, 1, 1, 1, 0, 0);
    send(REQ_READ, 0, 0, 0, 0, 0, 0, 10'd5);
    send(REQ_GLYPH, 124, 60, 0, 0, 1, 8'd255, 0);
    send(REQ_GLYPH, 20, 20, 0, 0, 1, 8'd0, 0);
    send(REQ_GLYPH, 30, 9, 0, 0, 1, 8'd126, 0);
    send(REQ_GLYPH, 30, 9, 0, 0, 0, 8'd32, 0);
    send(3'd6, 0, 0, 0, 0, 1, 0, 0);
    send(3'd7, 0, 0, 0, 0, 1, 0, 0);
    for (int i = 0; i < 5; i++) send(REQ_READ, 0, 0, 0, 0, 0, 0, 10'(1019 + i));
    // long receiver hold-off while reads keep coming
    hold_off = 1;
    for (int i = 0; i < 20; i++) send(REQ_READ, 0, 0, 0, 0, 0, 0, 10'($urandom));
    for (int i = 0; i < 533; i++) rnd_item();
    in_valid <= 0;
    waited = 0;
    while (fs.read_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    $display("ran about 580 requests of all kinds with clipping extremes and a long stall");
    $display("%0d read requests sent, %0d read-backs checked", n_reads, fs.checked);
    if (fs.errors == 0 && fs.read_q.size() == 0)
      $display("** page_framebuffer_draw_engine: PASSED **");
    else
      $display("** page_framebuffer_draw_engine: FAILED **");
    $finish;
  end
endmodule
